FILE: rtl/ps2mt_pkg.sv
// Shared types, constants and helper functions of the PS/2 mouse packet tracker.
package ps2mt_pkg;

    // Width of a cursor coordinate and of a limit register.
    localparam int COORD_BITS   = 12;
    localparam int PACKET_BYTES = 3;
    localparam int SLOT_BITS    = 2;
    localparam int DELTA_BITS   = 9;

    // Reset values of the limit registers.
    localparam logic [COORD_BITS-1:0] X_LIMIT_RESET = COORD_BITS'(640);
    localparam logic [COORD_BITS-1:0] Y_LIMIT_RESET = COORD_BITS'(480);

    // Configuration register indexes.
    localparam logic REG_X_LIMIT = 1'b0;
    localparam logic REG_Y_LIMIT = 1'b1;

    // Bit positions in the status byte.
    localparam int BIT_LEFT   = 0;
    localparam int BIT_RIGHT  = 1;
    localparam int BIT_MIDDLE = 2;
    localparam int BIT_SYNC   = 3;
    localparam int BIT_X_SIGN = 4;
    localparam int BIT_Y_SIGN = 5;
    localparam int BIT_X_OVF  = 6;
    localparam int BIT_Y_OVF  = 7;

    // Byte slot codes of the packet assembler.
    localparam logic [SLOT_BITS-1:0] SLOT_IDLE   = SLOT_BITS'(0);
    localparam logic [SLOT_BITS-1:0] SLOT_STATUS = SLOT_BITS'(1);
    localparam logic [SLOT_BITS-1:0] SLOT_LAST   = SLOT_BITS'(PACKET_BYTES - 1);

    typedef logic [COORD_BITS-1:0]         coord_t;
    typedef logic signed [COORD_BITS+1:0]  coord_sum_t;

    // One decoded packet as it travels from the front to the back.
    typedef struct packed {
        logic signed [DELTA_BITS-1:0] dx;
        logic signed [DELTA_BITS-1:0] dy;
        logic                         left;
        logic                         right;
        logic                         middle;
    } pkt_t;

    // A packet together with its valid flag.
    typedef struct packed {
        logic valid;
        pkt_t pkt;
    } pkt_word_t;

    // Screen limits handed to the back end.
    typedef struct packed {
        coord_t x_limit;
        coord_t y_limit;
    } limits_t;

    // Clamp a signed sum into 0..limit.
    function automatic coord_t clamp_pos(input coord_sum_t v, input coord_t limit);
        coord_sum_t top_ext;
        top_ext = coord_sum_t'({2'b00, limit});
        if (v < 0)
            return '0;
        else if (v > top_ext)
            return limit;
        else
            return v[COORD_BITS-1:0];
    endfunction

endpackage

FILE: rtl/ps2mt_if.sv
// Handshake interfaces for the mouse byte channel and the cursor result channel.
interface ps2mt_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface ps2mt_cursor_if import ps2mt_pkg::*;
;
    logic   valid;
    logic   ready;
    coord_t cursor_x;
    coord_t cursor_y;
    logic   left_pressed;
    logic   right_pressed;
    logic   middle_pressed;

    modport source (
        output valid, output cursor_x, output cursor_y,
        output left_pressed, output right_pressed, output middle_pressed,
        input ready
    );
    modport sink (
        input valid, input cursor_x, input cursor_y,
        input left_pressed, input right_pressed, input middle_pressed,
        output ready
    );
endinterface

FILE: rtl/ps2_mouse_packet_tracker.sv
// Top level of the PS/2 mouse packet tracker: limit registers and the front, queue and back.
// Usage:
// - rx carries one mouse byte per word. Bytes are taken at one per cycle; the only stall
//   is on the third byte of a packet while the packet queue is full.
// - A packet opens on a byte with bit 3 set; other bytes seen between packets are dropped.
// - Packets with an overflow bit set are discarded and produce no word on cursor.
// - cursor carries the clamped X/Y position and the three button bits, one word per
//   good packet. The packet enters the queue when its third byte is accepted; the back end
//   then adds, clamps and registers it once the output register is free or being drained.
// - Throughput is one byte per cycle unless rx stalls; the back end retires one packet per
//   cycle while cursor is not stalled, through a single add and clamp for each axis.
// - When cursor is stalled the result word waits in the output register and the queue
//   (QUEUE_DEPTH packets) absorbs further packets before rx stalls.
// - The limit registers are written through cfg_we/cfg_index/cfg_data, by the user only while
//   the block is idle; the block does not check it. Index 0 is the X limit, index 1 the Y limit.
// - Reset clears the position to 0,0, sets the limits to 640 and 480, drops any
//   partially received packet and empties the queue.
module ps2_mouse_packet_tracker import ps2mt_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    ps2mt_byte_if.sink            rx,
    ps2mt_cursor_if.source        cursor,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [COORD_BITS-1:0] cfg_data
);

    coord_t    x_limit_reg;
    coord_t    y_limit_reg;
    limits_t   limits;
    pkt_word_t q_push;
    pkt_word_t q_head;
    logic      q_full;
    logic      q_take;

    // Limit registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_limit_reg <= X_LIMIT_RESET;
            y_limit_reg <= Y_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_X_LIMIT: x_limit_reg <= cfg_data;
                REG_Y_LIMIT: y_limit_reg <= cfg_data;
                default:     x_limit_reg <= x_limit_reg;
            endcase
        end
    end

    assign limits.x_limit = x_limit_reg;
    assign limits.y_limit = y_limit_reg;

    ps2mt_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx),
        .q_full (q_full),
        .push   (q_push)
    );

    ps2mt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .full  (q_full),
        .take  (q_take),
        .head  (q_head)
    );

    ps2mt_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .limits (limits),
        .head   (q_head),
        .take   (q_take),
        .cursor (cursor)
    );

`ifndef SYNTHESIS
    // The front end never completes a packet into a full queue.
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push.valid |-> !q_full)
        else $error("packet pushed into a full queue");

    // The back end only takes a packet that the queue holds.
    a_take_has_packet: assert property (@(posedge clk) disable iff (!rst_n)
        q_take |-> q_head.valid)
        else $error("back end took from an empty queue");

    // A taken packet shows up as a result word in the next cycle.
    a_take_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
        q_take |=> cursor.valid)
        else $error("taken packet produced no result word");
`endif

endmodule

FILE: rtl/ps2mt_front.sv
// Front end: synchronizes on the status byte, assembles packets and drops overflow packets.
module ps2mt_front import ps2mt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    ps2mt_byte_if.sink         rx,
    input  logic               q_full,
    output pkt_word_t          push
);

    logic [SLOT_BITS-1:0] slot_reg;
    logic [SLOT_BITS-1:0] slot_next;
    logic [7:0]           status_reg;
    logic [7:0]           status_next;
    logic [7:0]           dx_reg;
    logic [7:0]           dx_next;
    logic                 final_slot;
    logic                 accept;

    // The final byte needs queue space; earlier bytes are always taken.
    assign final_slot = (slot_reg >= SLOT_LAST);
    assign rx.ready   = !final_slot || !q_full;
    assign accept     = rx.valid && rx.ready;

    // Slot sequencing and byte capture.
    always_comb
    begin
        slot_next   = slot_reg;
        status_next = status_reg;
        dx_next     = dx_reg;
        if (accept)
        begin
            case (slot_reg)
                SLOT_IDLE:
                begin
                    if (rx.rx_byte[BIT_SYNC])
                    begin
                        status_next = rx.rx_byte;
                        slot_next   = SLOT_STATUS;
                    end
                end
                SLOT_STATUS:
                begin
                    dx_next   = rx.rx_byte;
                    slot_next = SLOT_LAST;
                end
                default:
                begin
                    slot_next = SLOT_IDLE;
                end
            endcase
        end
    end

    // A complete packet without overflow goes to the queue.
    always_comb
    begin
        push.valid      = accept && final_slot &&
                          !status_reg[BIT_X_OVF] && !status_reg[BIT_Y_OVF];
        push.pkt.dx     = {status_reg[BIT_X_SIGN], dx_reg};
        push.pkt.dy     = {status_reg[BIT_Y_SIGN], rx.rx_byte};
        push.pkt.left   = status_reg[BIT_LEFT];
        push.pkt.right  = status_reg[BIT_RIGHT];
        push.pkt.middle = status_reg[BIT_MIDDLE];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= SLOT_IDLE;
        end
        else
        begin
            slot_reg <= slot_next;
        end
    end

    // The held bytes are written before they are read and need no reset.
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        dx_reg     <= dx_next;
    end

endmodule

FILE: rtl/ps2mt_queue.sv
// Small packet queue between the front end and the back end.
module ps2mt_queue import ps2mt_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  pkt_word_t push,
    output logic      full,
    input  logic      take,
    output pkt_word_t head
);

    localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_BITS = $clog2(DEPTH + 1);

    pkt_t                  mem_reg [DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg;
    logic [PTR_BITS-1:0]   wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg;
    logic [PTR_BITS-1:0]   rd_ptr_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic                  do_push;
    logic                  do_pop;

    assign full     = (count_reg == COUNT_BITS'(DEPTH));
    assign do_push  = push.valid && !full;
    assign do_pop   = take && (count_reg != '0);
    assign head.valid = (count_reg != '0);
    assign head.pkt   = mem_reg[rd_ptr_reg];

    // Pointer wrap and fill count.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage for queued packets.
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push.pkt;
    end

endmodule

FILE: rtl/ps2mt_back.sv
// Back end: applies packet deltas to the cursor position, clamps it and holds the result word.
module ps2mt_back import ps2mt_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  limits_t         limits,
    input  pkt_word_t       head,
    output logic            take,
    ps2mt_cursor_if.source  cursor
);

    coord_t     pos_x_reg;
    coord_t     pos_x_next;
    coord_t     pos_y_reg;
    coord_t     pos_y_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [2:0] buttons_reg;
    coord_sum_t sum_x;
    coord_sum_t sum_y;

    // A packet is taken whenever the output word is free or being drained.
    assign take = head.valid && (!out_valid_reg || cursor.ready);

    // Screen Y grows downward, so the Y delta is subtracted.
    assign sum_x = coord_sum_t'({2'b00, pos_x_reg}) + coord_sum_t'(head.pkt.dx);
    assign sum_y = coord_sum_t'({2'b00, pos_y_reg}) - coord_sum_t'(head.pkt.dy);

    always_comb
    begin
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        out_valid_next = out_valid_reg;
        if (cursor.ready)
            out_valid_next = 1'b0;
        if (take)
        begin
            pos_x_next     = clamp_pos(sum_x, limits.x_limit);
            pos_y_next     = clamp_pos(sum_y, limits.y_limit);
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Button bits travel with the word they belong to.
    always_ff @(posedge clk)
    begin
        if (take)
            buttons_reg <= {head.pkt.middle, head.pkt.right, head.pkt.left};
    end

    assign cursor.valid          = out_valid_reg;
    assign cursor.cursor_x       = pos_x_reg;
    assign cursor.cursor_y       = pos_y_reg;
    assign cursor.left_pressed   = buttons_reg[0];
    assign cursor.right_pressed  = buttons_reg[1];
    assign cursor.middle_pressed = buttons_reg[2];

endmodule
